// File: hdl/hlm_pkg.sv
package hlm_pkg;

  localparam int ENTRIES_DEFAULT = 1024;

  localparam int KIND_W     = 2;
  localparam int ENTRY_W    = 10;
  localparam int TIME_W     = 32;
  localparam int INTERVAL_W = 16;
  localparam int MISS_W     = 4;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd20;
  localparam logic [MISS_W-1:0]     RETRY_RESET    = 4'd3;

  // register indexes on the config port
  localparam logic CFG_INTERVAL = 1'b0;
  localparam logic CFG_RETRY    = 1'b1;

  // result codes
  localparam logic ACT_HEARTBEAT = 1'b0;
  localparam logic ACT_OFFLINE   = 1'b1;

  // output queue depth: covers one word waiting, one in flight, one being computed
  localparam int OQ_DEPTH = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_CONNECT  = 2'd0,
    KIND_ACTIVITY = 2'd1,
    KIND_CHECK    = 2'd2,
    KIND_CLOSE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    LINK_FREE      = 2'd0,
    LINK_CONNECTED = 2'd1,
    LINK_OFFLINE   = 2'd2
  } link_t;

  typedef struct packed {
    link_t              link;
    logic [MISS_W-1:0]  miss;
  } status_t;

  typedef struct packed {
    logic               valid;
    logic               action;
    logic [ENTRY_W-1:0] entry;
  } result_t;

  typedef struct packed {
    logic clearing;
    logic pending;
  } core_status_t;

endpackage

// File: hdl/heartbeat_liveness_monitor_top.sv
// Channel   Dir  Word                         Accepted when
// s_*       in   tuser: kind[1:0]             s_tvalid && s_tready
//                tdata: entry[9:0], now[41:10]
// m_*       out  tuser: action[0]             m_tvalid && m_tready
//                tdata: entry_out[9:0]
// cfg_*     in   index 0 interval, 1 retries  cfg_we high
//
// One word per cycle sustained while s_tready is high. The table RAMs are read
// at the edge that takes the word; compute and write-back follow in the compute
// stage, and the result is registered into the output queue that drives m_tvalid.
// Back-to-back words on the same entry are served by forwarding the last write.
// After rst the status table is swept clear entry by entry; s_tready is low
// meanwhile, config writes still land.
// s_tready drops when the three-word result queue could overflow, i.e. while
// results pile up with m_tready held low.
module heartbeat_liveness_monitor_top #(
  parameter int ENTRIES = hlm_pkg::ENTRIES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [47:0]                     s_tdata,  // entry[9:0], now[41:10], zero pad
  input  logic [hlm_pkg::KIND_W-1:0]      s_tuser,  // kind[1:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [15:0]                     m_tdata,  // entry_out[9:0], zero pad
  output logic [0:0]                      m_tuser,  // action[0]
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [hlm_pkg::INTERVAL_W-1:0]  cfg_wdata
);

  logic [hlm_pkg::INTERVAL_W-1:0] interval;
  logic [hlm_pkg::MISS_W-1:0]     retry_limit;

  hlm_pkg::core_status_t          core_st;
  hlm_pkg::result_t               res;
  logic                           in_accept;
  logic                           pop;
  logic                           q_action;
  logic [hlm_pkg::ENTRY_W-1:0]    q_entry;
  logic [1:0]                     q_count;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      interval    <= hlm_pkg::INTERVAL_RESET;
      retry_limit <= hlm_pkg::RETRY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        hlm_pkg::CFG_INTERVAL: interval    <= cfg_wdata;
        hlm_pkg::CFG_RETRY:    retry_limit <= cfg_wdata[hlm_pkg::MISS_W-1:0];
        default:               interval    <= interval;
      endcase
    end
  end

  // room for the word now in compute plus the one taken here, ignoring this cycle's pop
  assign s_tready  = !core_st.clearing &&
                     ({1'b0, q_count} + {2'b00, core_st.pending} <= 3'd2);
  assign in_accept = s_tvalid && s_tready;
  assign pop       = m_tvalid && m_tready;

  hlm_core #(.ENTRIES(ENTRIES)) u_core (
    .clk         (clk),
    .rst         (rst),
    .in_accept   (in_accept),
    .in_kind     (hlm_pkg::kind_t'(s_tuser)),
    .in_entry    (s_tdata[hlm_pkg::ENTRY_W-1:0]),
    .in_now      (s_tdata[hlm_pkg::ENTRY_W +: hlm_pkg::TIME_W]),
    .interval    (interval),
    .retry_limit (retry_limit),
    .status      (core_st),
    .res         (res)
  );

  hlm_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (res),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_action (q_action),
    .out_entry  (q_entry),
    .count      (q_count)
  );

  assign m_tdata = {{(16 - hlm_pkg::ENTRY_W){1'b0}}, q_entry};
  assign m_tuser = q_action;

endmodule

// File: hdl/hlm_ram.sv
module hlm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/hlm_core.sv
module hlm_core #(
  parameter int ENTRIES = hlm_pkg::ENTRIES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_accept,
  input  hlm_pkg::kind_t                   in_kind,
  input  logic [hlm_pkg::ENTRY_W-1:0]      in_entry,
  input  logic [hlm_pkg::TIME_W-1:0]       in_now,
  input  logic [hlm_pkg::INTERVAL_W-1:0]   interval,
  input  logic [hlm_pkg::MISS_W-1:0]       retry_limit,
  output hlm_pkg::core_status_t            status,
  output hlm_pkg::result_t                 res
);

  localparam int AW = $clog2(ENTRIES);
  localparam int SW = $bits(hlm_pkg::status_t);
  localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

  // reset sweep over the status store
  logic          clearing;
  logic [AW-1:0] clear_addr;

  // compute stage
  logic                          s1_valid;
  hlm_pkg::kind_t                s1_kind;
  logic [AW-1:0]                 s1_addr;
  logic [hlm_pkg::ENTRY_W-1:0]   s1_entry;
  logic [hlm_pkg::TIME_W-1:0]    s1_now;

  // last write, forwarded to a back-to-back access of the same entry
  logic                          fwd_valid;
  logic [AW-1:0]                 fwd_addr;
  hlm_pkg::status_t              fwd_st;
  logic [hlm_pkg::TIME_W-1:0]    fwd_tm;

  logic [SW-1:0]                 st_rd;
  logic [hlm_pkg::TIME_W-1:0]    tm_rd;
  hlm_pkg::status_t              st_cur;
  hlm_pkg::status_t              st_new;
  logic [hlm_pkg::TIME_W-1:0]    tm_cur;
  logic [hlm_pkg::TIME_W-1:0]    tm_new;
  logic [hlm_pkg::TIME_W:0]      due;
  logic                          now_due;
  logic                          hb_fire;
  logic                          off_fire;
  logic                          in_range;
  logic [AW-1:0]                 raddr;
  logic                          st_we;
  logic [AW-1:0]                 st_waddr;
  logic [SW-1:0]                 st_wdata;

  assign in_range = 32'(in_entry) < ENTRIES;
  assign raddr    = AW'(in_entry);

  assign st_we    = clearing | s1_valid;
  assign st_waddr = clearing ? clear_addr : s1_addr;
  assign st_wdata = clearing ? '0 : st_new;

  hlm_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_status_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (raddr),
    .rdata (st_rd)
  );

  hlm_ram #(.WIDTH(hlm_pkg::TIME_W), .DEPTH(ENTRIES)) u_time_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_addr),
    .wdata (tm_new),
    .raddr (raddr),
    .rdata (tm_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      if (clear_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end else begin
        clear_addr <= clear_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      s1_valid  <= in_accept & in_range;
      fwd_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_kind  <= in_kind;
    s1_addr  <= raddr;
    s1_entry <= in_entry;
    s1_now   <= in_now;
    fwd_addr <= s1_addr;
    fwd_st   <= st_new;
    fwd_tm   <= tm_new;
  end

  always_comb begin
    if (fwd_valid && fwd_addr == s1_addr) begin
      st_cur = fwd_st;
      tm_cur = fwd_tm;
    end else begin
      st_cur = hlm_pkg::status_t'(st_rd);
      tm_cur = tm_rd;
    end
  end

  // no wrap handling on the due time
  assign due      = {1'b0, tm_cur} + {{(hlm_pkg::TIME_W + 1 - hlm_pkg::INTERVAL_W){1'b0}}, interval};
  assign now_due  = {1'b0, s1_now} >= due;
  assign hb_fire  = st_cur.link == hlm_pkg::LINK_CONNECTED && now_due && st_cur.miss < retry_limit;
  assign off_fire = !hb_fire && st_cur.miss == retry_limit;

  always_comb begin
    st_new     = st_cur;
    tm_new     = tm_cur;
    res.valid  = 1'b0;
    res.action = hlm_pkg::ACT_HEARTBEAT;
    res.entry  = s1_entry;
    case (s1_kind)
      hlm_pkg::KIND_CONNECT: begin
        st_new.link = hlm_pkg::LINK_CONNECTED;
        st_new.miss = '0;
        tm_new      = s1_now;
      end
      hlm_pkg::KIND_ACTIVITY: begin
        st_new.miss = '0;
        tm_new      = s1_now;
      end
      hlm_pkg::KIND_CLOSE: begin
        st_new.link = hlm_pkg::LINK_FREE;
        st_new.miss = '0;
        tm_new      = '0;
      end
      hlm_pkg::KIND_CHECK: begin
        if (hb_fire) begin
          st_new.miss = st_cur.miss + hlm_pkg::MISS_W'(1);
          tm_new      = s1_now;
          res.valid   = s1_valid;
          res.action  = hlm_pkg::ACT_HEARTBEAT;
        end else if (off_fire) begin
          st_new.link = hlm_pkg::LINK_OFFLINE;
          st_new.miss = '0;
          res.valid   = s1_valid;
          res.action  = hlm_pkg::ACT_OFFLINE;
        end
      end
      default: begin
        st_new = st_cur;
      end
    endcase
  end

  assign status.clearing = clearing;
  assign status.pending  = s1_valid;

endmodule

// File: hdl/hlm_outq.sv
module hlm_outq (
  input  logic                         clk,
  input  logic                         rst,
  input  hlm_pkg::result_t             push,
  input  logic                         pop,
  output logic                         out_valid,
  output logic                         out_action,
  output logic [hlm_pkg::ENTRY_W-1:0]  out_entry,
  output logic [1:0]                   count
);

  localparam int PW = $clog2(hlm_pkg::OQ_DEPTH);
  localparam logic [PW-1:0] LAST = PW'(hlm_pkg::OQ_DEPTH - 1);

  logic [hlm_pkg::ENTRY_W:0] slot [hlm_pkg::OQ_DEPTH];
  logic [PW-1:0]             head;
  logic [PW-1:0]             tail;
  logic [1:0]                count_next;

  always_comb begin
    count_next = count;
    if (push.valid && !pop) begin
      count_next = count + 2'd1;
    end else if (!push.valid && pop) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (push.valid) begin
        tail <= (tail == LAST) ? '0 : tail + PW'(1);
      end
      if (pop) begin
        head <= (head == LAST) ? '0 : head + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slot[tail] <= {push.action, push.entry};
    end
  end

  assign out_valid  = count != 2'd0;
  assign out_action = slot[head][hlm_pkg::ENTRY_W];
  assign out_entry  = slot[head][hlm_pkg::ENTRY_W-1:0];

endmodule

// File: hdl/hlm_checker.sv
module hlm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // table sweep after reset blocks input
  a_reset_blocks_input: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input taken right after reset");

  // queue empty after reset
  a_reset_no_output: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result shown right after reset");

  // a fresh result comes from a word taken earlier, via the compute stage and the output queue
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without matching input word");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind heartbeat_liveness_monitor_top hlm_checker u_hlm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: tb/tb_heartbeat_liveness_monitor_top.sv
module tb_heartbeat_liveness_monitor_top;
  import hlm_pkg::*;

  localparam int N_ENTRIES   = ENTRIES_DEFAULT;
  localparam int TAIL_CYCLES = 8;       // compute stage and output queue, plus margin
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 225;
  localparam int DRAIN_LIMIT = 20000;   // cycles to wait for results before giving up
  localparam int HOT_SET     = 8;

  // verdict of a directed row: typed in, or left to the table model
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_HEARTBEAT,
    CHK_OFFLINE
  } verdict_t;

  typedef struct packed {
    kind_t               kind;
    logic [ENTRY_W-1:0]  entry;
    logic [TIME_W-1:0]   now;
    verdict_t            verdict;
  } step_row_t;

  typedef struct packed {
    logic                action;
    logic [ENTRY_W-1:0]  entry;
  } link_action_t;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input holds a known value from time zero
  // ---------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [47:0]           s_tdata   = '0;   // entry[9:0], now[41:10], zero pad
  logic [KIND_W-1:0]     s_tuser   = '0;   // kind[1:0]
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [15:0]           m_tdata;          // entry_out[9:0], zero pad
  logic [0:0]            m_tuser;          // action[0]
  logic                  cfg_we    = 1'b0;
  logic                  cfg_index = 1'b0;
  logic [INTERVAL_W-1:0] cfg_wdata = '0;

  always #4 clk = ~clk;

  heartbeat_liveness_monitor_top #(
    .ENTRIES(N_ENTRIES)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Liveness table model: own copy of the per-entry state and the registers
  // ---------------------------------------------------------------------------
  link_t              link_tbl  [N_ENTRIES];
  logic [TIME_W-1:0]  stamp_tbl [N_ENTRIES];
  logic [MISS_W-1:0]  miss_tbl  [N_ENTRIES];
  logic [INTERVAL_W-1:0] hb_interval = INTERVAL_RESET;
  logic [MISS_W-1:0]     retry_max   = RETRY_RESET;

  // entries whose time stamp was written at least once; checks only go there
  bit [N_ENTRIES-1:0] stamped = '0;

  link_action_t pending_actions[$];
  link_action_t head_exp;

  step_row_t plan[$];
  logic [ENTRY_W-1:0] hot[HOT_SET];
  logic [TIME_W-1:0]  wall_sec = '0;

  int send_idle_pct = 30;
  int recv_idle_pct = 54;
  int mismatches    = 0;
  int words_sent    = 0;
  int results_seen  = 0;
  int heartbeat_seen = 0;
  int offline_seen  = 0;

  initial begin
    foreach (link_tbl[i]) begin
      link_tbl[i]  = LINK_FREE;
      stamp_tbl[i] = '0;
      miss_tbl[i]  = '0;
    end
  end

  // Returns 1 when the event yields a result; act carries its action code.
  function automatic bit predict_event(input kind_t k, input logic [ENTRY_W-1:0] e,
                                       input logic [TIME_W-1:0] t, output logic act);
    logic [TIME_W:0] due;
    act = ACT_HEARTBEAT;
    case (k)
      KIND_CONNECT: begin
        link_tbl[e]  = LINK_CONNECTED;
        stamp_tbl[e] = t;
        miss_tbl[e]  = '0;
        return 1'b0;
      end
      KIND_ACTIVITY: begin
        // link state untouched, even on a free or offline entry
        stamp_tbl[e] = t;
        miss_tbl[e]  = '0;
        return 1'b0;
      end
      KIND_CLOSE: begin
        link_tbl[e]  = LINK_FREE;
        stamp_tbl[e] = '0;
        miss_tbl[e]  = '0;
        return 1'b0;
      end
      default: ;
    endcase
    // due time kept at 33 bits: no wrap handling
    due = {1'b0, stamp_tbl[e]} + {{(TIME_W + 1 - INTERVAL_W){1'b0}}, hb_interval};
    if (link_tbl[e] == LINK_CONNECTED && {1'b0, t} >= due && miss_tbl[e] < retry_max) begin
      stamp_tbl[e] = t;
      miss_tbl[e]  = miss_tbl[e] + 1'b1;
      act = ACT_HEARTBEAT;
      return 1'b1;
    end
    // offline test ignores link state; a count above the limit matches nothing
    if (miss_tbl[e] == retry_max) begin
      link_tbl[e] = LINK_OFFLINE;
      miss_tbl[e] = '0;
      act = ACT_OFFLINE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic step_row_t step_row(input kind_t k, input int e,
                                         input logic [TIME_W-1:0] t, input verdict_t v);
    step_row_t r;
    r.kind    = k;
    r.entry   = e[ENTRY_W-1:0];
    r.now     = t;
    r.verdict = v;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: one event word per call, random gaps before it. Called at a
  // rising edge; returns at the edge where the word was taken.
  // ---------------------------------------------------------------------------
  task automatic send_event(input kind_t k, input logic [ENTRY_W-1:0] e,
                            input logic [TIME_W-1:0] t, input verdict_t v);
    logic         act;
    bit           fired;
    link_action_t exp_res;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= {6'b0, t, e};
    do @(posedge clk); while (!s_tready);
    words_sent++;
    if (k != KIND_CHECK)
      stamped[e] = 1'b1;
    fired = predict_event(k, e, t, act);
    exp_res.entry = e;
    case (v)
      CHK_MODEL: begin
        exp_res.action = act;
        if (fired)
          pending_actions.push_back(exp_res);
      end
      CHK_HEARTBEAT: begin
        exp_res.action = ACT_HEARTBEAT;
        pending_actions.push_back(exp_res);
      end
      CHK_OFFLINE: begin
        exp_res.action = ACT_OFFLINE;
        pending_actions.push_back(exp_res);
      end
      default: ;
    endcase
  endtask

  // Mostly well-formed traffic on a small hot set with a steadily advancing
  // clock, so entries walk through heartbeats to offline; the rest is noise
  // over the whole table and the whole time range.
  task automatic random_event();
    kind_t              k;
    logic [ENTRY_W-1:0] e;
    logic [TIME_W-1:0]  t;
    int                 r;
    r = $urandom_range(0, 99);
    wall_sec = wall_sec + $urandom_range(0, (int'(hb_interval) + 3) / 4);
    e = hot[$urandom_range(0, HOT_SET - 1)];
    t = wall_sec;
    if (r < 75)
      k = KIND_CHECK;
    else if (r < 81)
      k = KIND_ACTIVITY;
    else if (r < 84)
      k = KIND_CONNECT;
    else if (r < 85)
      k = KIND_CLOSE;
    else begin
      k = kind_t'($urandom_range(0, 3));
      e = ENTRY_W'($urandom_range(0, N_ENTRIES - 1));
      t = $urandom;
    end
    // bring dead hot entries back now and then
    if (k == KIND_CHECK && r < 75 && link_tbl[e] != LINK_CONNECTED
        && $urandom_range(0, 3) == 0)
      k = KIND_CONNECT;
    // never check an entry whose time stamp was never written
    if (k == KIND_CHECK && !stamped[e])
      k = KIND_CONNECT;
    send_event(k, e, t, CHK_MODEL);
  endtask

  // Register write while idle; the model follows at the same edge.
  task automatic write_reg(input logic idx, input logic [INTERVAL_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_INTERVAL)
      hb_interval = val;
    else
      retry_max = val[MISS_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every outstanding result, then let the pipe settle.
  task automatic drain_results();
    int waited;
    waited = 0;
    while (pending_actions.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random backpressure; each taken word is matched to the oldest
  // expectation field by field
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_actions.size() == 0) begin
        report_mismatch($sformatf("unexpected result action=%0d entry=%0d",
                                  m_tuser[0], m_tdata[ENTRY_W-1:0]));
      end else begin
        head_exp = pending_actions.pop_front();
        results_seen++;
        if (head_exp.action == ACT_OFFLINE)
          offline_seen++;
        else
          heartbeat_seen++;
        if (m_tuser[0] !== head_exp.action)
          report_mismatch($sformatf("action %0d, expected %0d (entry %0d)",
                                    m_tuser[0], head_exp.action, head_exp.entry));
        if (m_tdata[ENTRY_W-1:0] !== head_exp.entry)
          report_mismatch($sformatf("entry_out %0d, expected %0d",
                                    m_tdata[ENTRY_W-1:0], head_exp.entry));
      end
    end
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    foreach (hot[i])
      hot[i] = ENTRY_W'($urandom_range(0, N_ENTRIES - 1));

    // Directed rows, reset settings (interval 20, limit 3).
    // Entry 0: not due one second early, due exactly on time, three requests,
    // then offline, then silent while offline.
    plan.push_back(step_row(KIND_CONNECT,  0, 32'd0,  CHK_NONE));
    plan.push_back(step_row(KIND_CHECK,    0, 32'd19, CHK_NONE));
    plan.push_back(step_row(KIND_CHECK,    0, 32'd20, CHK_HEARTBEAT));
    plan.push_back(step_row(KIND_CHECK,    0, 32'd40, CHK_HEARTBEAT));
    plan.push_back(step_row(KIND_CHECK,    0, 32'd60, CHK_HEARTBEAT));
    plan.push_back(step_row(KIND_CHECK,    0, 32'd61, CHK_OFFLINE));
    plan.push_back(step_row(KIND_CHECK,    0, 32'd500, CHK_NONE));
    // top entry, top time: the due sum carries out of 32 bits, so not due
    plan.push_back(step_row(KIND_CONNECT,  1023, 32'hFFFF_FFFF, CHK_NONE));
    plan.push_back(step_row(KIND_CHECK,    1023, 32'hFFFF_FFFF, CHK_NONE));
    // activity on a free entry stamps time but leaves it free
    plan.push_back(step_row(KIND_ACTIVITY, 5, 32'd100, CHK_NONE));
    plan.push_back(step_row(KIND_CHECK,    5, 32'd500, CHK_NONE));
    // alternating bit patterns, then close clears the entry
    plan.push_back(step_row(KIND_CONNECT,  'h2AA, 32'h5555_5555, CHK_NONE));
    plan.push_back(step_row(KIND_ACTIVITY, 'h2AA, 32'hAAAA_AAAA, CHK_NONE));
    plan.push_back(step_row(KIND_CHECK,    'h2AA, 32'hAAAA_AABE, CHK_HEARTBEAT));
    plan.push_back(step_row(KIND_CLOSE,    'h2AA, 32'h0000_1234, CHK_NONE));
    plan.push_back(step_row(KIND_CHECK,    'h2AA, 32'hFFFF_FFFF, CHK_NONE));
    // connect over an offline entry, then over a busy one, back to back
    plan.push_back(step_row(KIND_CONNECT,  0, 32'd300, CHK_NONE));
    plan.push_back(step_row(KIND_CHECK,    0, 32'd320, CHK_MODEL));
    plan.push_back(step_row(KIND_CONNECT,  0, 32'd321, CHK_MODEL));
    plan.push_back(step_row(KIND_CHECK,    0, 32'd340, CHK_MODEL));
    plan.push_back(step_row(KIND_CHECK,    0, 32'd341, CHK_MODEL));
    plan.push_back(step_row(KIND_CONNECT,  'h155, 32'h0000_FFFF, CHK_MODEL));
    plan.push_back(step_row(KIND_CHECK,    'h155, 32'h8000_0000, CHK_MODEL));
    plan.push_back(step_row(KIND_ACTIVITY, 1023, 32'd0, CHK_MODEL));
    plan.push_back(step_row(KIND_CHECK,    1023, 32'd20, CHK_MODEL));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // s_tready stays low through the post-reset sweep; send_event waits on it
    foreach (plan[i])
      send_event(plan[i].kind, plan[i].entry, plan[i].now, plan[i].verdict);

    for (int p = 0; p < PHASES; p++) begin
      // stall the sender until the table is idle, then retune
      s_tvalid <= 1'b0;
      drain_results();
      case (p)
        0: begin
          write_reg(CFG_INTERVAL, 16'd1);
          write_reg(CFG_RETRY, 16'd1);
        end
        1: begin
          write_reg(CFG_INTERVAL, 16'd65535);
          write_reg(CFG_RETRY, 16'd15);
        end
        2: begin
          // limit drops below counts left over from the last phase
          write_reg(CFG_INTERVAL, 16'($urandom_range(2, 200)));
          write_reg(CFG_RETRY, 16'd1);
        end
        3: begin
          write_reg(CFG_INTERVAL, 16'($urandom_range(1, 65535)));
          write_reg(CFG_RETRY, 16'($urandom_range(1, 15)));
        end
        4: begin
          write_reg(CFG_INTERVAL, 16'd300);
          write_reg(CFG_RETRY, 16'd15);
        end
        default: begin
          write_reg(CFG_INTERVAL, 16'd7);
          write_reg(CFG_RETRY, 16'd8);
        end
      endcase
      // pairs of phases: receiver-heavy idling, sender-heavy, then none
      case (p / 2)
        0: begin
          send_idle_pct = 30;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 30;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (PHASE_WORDS) random_event();
    end

    s_tvalid <= 1'b0;
    drain_results();
    if (pending_actions.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_actions.size()));

    $display("covered %0d event words (%0d directed) and %0d results: %0d heartbeat, %0d offline",
             words_sent, plan.size(), results_seen, heartbeat_seen, offline_seen);
    $display("%0d register settings after reset, interval 1..65535, limit 1..15; %0d mismatches",
             PHASES, mismatches);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2000000;
    $display("timeout: run did not complete");
    $display("FAIL");
    $finish;
  end

endmodule
